/* hdl/bfh_pkg.sv */
// Shared constants, codes and types of the byte frequency histogram.
package bfh_pkg;

  localparam int SYMBOLS_DEF     = 256;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int SYMBOL_W    = 8;
  localparam int KIND_W      = 2;
  localparam int OUT_COUNT_W = 32;
  localparam int DISTINCT_W  = 9;

  // present-map scan looks at one group of lanes per cycle
  localparam int LANES  = 16;
  localparam int LANE_W = 4;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELD_W = SYMBOL_W + OUT_COUNT_W + DISTINCT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FETCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_SCAN,
    ST_FETCH_RD,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [SYMBOL_W-1:0]    symbol;
    logic [OUT_COUNT_W-1:0] count;
    logic                   entry_valid;
    logic                   last;
    logic [DISTINCT_W-1:0]  distinct;
  } result_t;

  typedef struct packed {
    logic set_en;
    logic clr_all;
  } pmap_cmd_t;

  typedef struct packed {
    logic hit;
    logic last_grp;
  } scan_stat_t;

endpackage

/* hdl/byte_frequency_histogram.sv */
// Byte frequency histogram top level: control sequencer and result register.
//
// Input stream: in_tuser carries the kind (add, fetch, clear), in_tdata the
// byte to count. Every accepted word gives exactly one result word.
// Result stream: out_tdata carries symbol, count and distinct count,
// out_tuser the entry-valid flag, out_tlast the last-present-entry flag.
//
// Steps per word, set by the count memory read and the present-map scan:
//   clear, unused kind, add of a byte beyond the table: finished while idle
//   add: count memory read, then increment and write back
//   fetch: search of G lane groups of 16 symbols (G is 1 to 16), then count read
//   fetch past the last present entry: search of G lane groups, no count read
// One word is worked on at a time; in_tready is high while idle.
// Results go through an output register, so a new word is taken while
// the previous result waits; a second finished result waits in a hold
// register and further input is held off until out_tready frees the slot.
// Reset clears the presence bits, the distinct and scan counters and the
// output valid; the count memory is not cleared, since an absent symbol
// is always rewritten before its count is read.
module byte_frequency_histogram #(
  parameter int SYMBOLS     = bfh_pkg::SYMBOLS_DEF,
  parameter int COUNT_WIDTH = bfh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bfh_pkg::IN_TDATA_W-1:0]   in_tdata,   // symbol_in[7:0]
  input  logic [bfh_pkg::KIND_W-1:0]       in_tuser,   // kind[1:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bfh_pkg::OUT_TDATA_W-1:0]  out_tdata,  // out_symbol[7:0], out_count[39:8],
                                                       // distinct_count[48:40], zeros above
  output logic [0:0]                       out_tuser,  // entry_valid[0]
  output logic                             out_tlast
);

  localparam int IDX_W   = $clog2(SYMBOLS);
  localparam int POS_W   = $clog2(SYMBOLS + 1);
  localparam int NGROUPS = (SYMBOLS + bfh_pkg::LANES - 1) / bfh_pkg::LANES;
  localparam int GRP_W   = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int PAD_W   = GRP_W + bfh_pkg::LANE_W;
  localparam int CUR_W   = PAD_W + 1;
  localparam int LANE_W  = bfh_pkg::LANE_W;
  localparam int DW      = bfh_pkg::DISTINCT_W;
  localparam int SW      = bfh_pkg::SYMBOL_W;
  localparam int OCW     = bfh_pkg::OUT_COUNT_W;

  bfh_pkg::state_t     state_r, state_nxt;
  logic [IDX_W-1:0]    sym_r, sym_nxt;
  logic [CUR_W-1:0]    cur_r, cur_nxt;
  logic [CUR_W-1:0]    scan_pos_r, scan_pos_nxt;
  logic [POS_W-1:0]    fetched_r, fetched_nxt;
  logic [POS_W-1:0]    distinct_r, distinct_nxt;
  bfh_pkg::result_t    hold_r, hold_nxt;
  bfh_pkg::result_t    out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [SW-1:0]               in_sym;
  logic [bfh_pkg::KIND_W-1:0]  in_kind;
  logic [IDX_W-1:0]            in_sym_idx;
  logic                        sym_ok;
  logic                        out_free;
  logic                        fin;
  bfh_pkg::result_t            fin_res;

  bfh_pkg::pmap_cmd_t          pcmd;
  bfh_pkg::scan_stat_t         stat;
  logic [IDX_W-1:0]            hit_idx;
  logic                        rd_present;

  logic                        ram_we;
  logic [COUNT_WIDTH-1:0]      ram_wdata;
  logic [IDX_W-1:0]            ram_raddr;
  logic [COUNT_WIDTH-1:0]      ram_rdata;
  logic [OCW+COUNT_WIDTH-1:0]  cnt_ext;

  logic [GRP_W:0]              grp_inc;
  logic [POS_W-1:0]            fetched_inc;

  assign in_sym     = in_tdata[SW-1:0];
  assign in_kind    = in_tuser;
  assign in_sym_idx = in_sym[IDX_W-1:0];
  assign sym_ok     = {1'b0, in_sym} < DW'(SYMBOLS);
  assign out_free   = !out_valid_r || out_tready;
  assign cnt_ext    = {{OCW{1'b0}}, ram_rdata};
  assign grp_inc    = cur_r[CUR_W-1:LANE_W] + 1'b1;
  assign fetched_inc = fetched_r + 1'b1;

  bfh_count_ram #(
    .DEPTH (SYMBOLS),
    .WIDTH (COUNT_WIDTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sym_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bfh_present_scan #(
    .SYMBOLS (SYMBOLS)
  ) u_present_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (pcmd),
    .set_idx    (sym_r),
    .rd_idx     (sym_r),
    .rd_present (rd_present),
    .cur        (cur_r),
    .stat       (stat),
    .hit_idx    (hit_idx)
  );

  always_comb begin
    state_nxt     = state_r;
    sym_nxt       = sym_r;
    cur_nxt       = cur_r;
    scan_pos_nxt  = scan_pos_r;
    fetched_nxt   = fetched_r;
    distinct_nxt  = distinct_r;
    hold_nxt      = hold_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = (state_r == bfh_pkg::ST_IDLE);
    fin           = 1'b0;
    fin_res       = '0;
    pcmd          = '0;
    ram_we        = 1'b0;
    ram_wdata     = '0;
    ram_raddr     = in_sym_idx;

    case (state_r)
      bfh_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          case (in_kind)
            bfh_pkg::KIND_ADD: begin
              scan_pos_nxt = '0;
              fetched_nxt  = '0;
              if (sym_ok) begin
                sym_nxt   = in_sym_idx;
                state_nxt = bfh_pkg::ST_ADD_WR;
              end else begin
                fin              = 1'b1;
                fin_res.distinct = DW'(distinct_r);
              end
            end
            bfh_pkg::KIND_FETCH: begin
              cur_nxt   = scan_pos_r;
              state_nxt = bfh_pkg::ST_SCAN;
            end
            bfh_pkg::KIND_CLEAR: begin
              pcmd.clr_all = 1'b1;
              distinct_nxt = '0;
              scan_pos_nxt = '0;
              fetched_nxt  = '0;
              fin          = 1'b1;
            end
            default: begin
              fin              = 1'b1;
              fin_res.distinct = DW'(distinct_r);
            end
          endcase
        end
      end

      bfh_pkg::ST_ADD_WR: begin
        ram_we = 1'b1;
        if (!rd_present) begin
          ram_wdata    = COUNT_WIDTH'(1);
          pcmd.set_en  = 1'b1;
          distinct_nxt = distinct_r + 1'b1;
        end else if (ram_rdata != '1) begin
          ram_wdata = ram_rdata + 1'b1;
        end else begin
          ram_wdata = ram_rdata;  // saturate
        end
        fin              = 1'b1;
        fin_res.distinct = DW'(distinct_nxt);
      end

      bfh_pkg::ST_SCAN: begin
        ram_raddr = hit_idx;
        if (stat.hit) begin
          sym_nxt   = hit_idx;
          state_nxt = bfh_pkg::ST_FETCH_RD;
        end else if (stat.last_grp) begin
          // scan exhausted: report no entry, leave the scan state alone
          fin              = 1'b1;
          fin_res.distinct = DW'(distinct_r);
        end else begin
          cur_nxt = {grp_inc, {LANE_W{1'b0}}};
        end
      end

      bfh_pkg::ST_FETCH_RD: begin
        fetched_nxt         = fetched_inc;
        scan_pos_nxt        = CUR_W'(sym_r) + 1'b1;
        fin                 = 1'b1;
        fin_res.symbol      = SW'(sym_r);
        fin_res.count       = cnt_ext[OCW-1:0];
        fin_res.entry_valid = 1'b1;
        fin_res.last        = fetched_inc >= distinct_r;
        fin_res.distinct    = DW'(distinct_r);
      end

      bfh_pkg::ST_HOLD: begin
        fin     = 1'b1;
        fin_res = hold_r;
      end

      default: begin
        state_nxt = bfh_pkg::ST_IDLE;
      end
    endcase

    // hand the finished word to the output register, or park it
    if (fin) begin
      if (out_free) begin
        out_nxt       = fin_res;
        out_valid_nxt = 1'b1;
        state_nxt     = bfh_pkg::ST_IDLE;
      end else begin
        hold_nxt  = fin_res;
        state_nxt = bfh_pkg::ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfh_pkg::ST_IDLE;
      scan_pos_r  <= '0;
      fetched_r   <= '0;
      distinct_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_pos_r  <= scan_pos_nxt;
      fetched_r   <= fetched_nxt;
      distinct_r  <= distinct_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r  <= sym_nxt;
    cur_r  <= cur_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{bfh_pkg::OUT_PAD_W{1'b0}}, out_r.distinct, out_r.count, out_r.symbol};
  assign out_tuser  = out_r.entry_valid;
  assign out_tlast  = out_r.last;

endmodule

/* hdl/bfh_count_ram.sv */
// Frequency count memory: one write port, one read port with registered data.
module bfh_count_ram #(
  parameter int DEPTH = bfh_pkg::SYMBOLS_DEF,
  parameter int WIDTH = bfh_pkg::COUNT_WIDTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/bfh_present_scan.sv */
// Presence bits per symbol and the lane-group search for the next present symbol.
module bfh_present_scan #(
  parameter int SYMBOLS  = bfh_pkg::SYMBOLS_DEF,
  localparam int IDX_W   = $clog2(SYMBOLS),
  localparam int NGROUPS = (SYMBOLS + bfh_pkg::LANES - 1) / bfh_pkg::LANES,
  localparam int GRP_W   = (NGROUPS > 1) ? $clog2(NGROUPS) : 1,
  localparam int PAD_W   = GRP_W + bfh_pkg::LANE_W,
  localparam int CUR_W   = PAD_W + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bfh_pkg::pmap_cmd_t     cmd,
  input  logic [IDX_W-1:0]       set_idx,
  input  logic [IDX_W-1:0]       rd_idx,
  output logic                   rd_present,
  input  logic [CUR_W-1:0]       cur,
  output bfh_pkg::scan_stat_t    stat,
  output logic [IDX_W-1:0]       hit_idx
);

  localparam int LANES  = bfh_pkg::LANES;
  localparam int LANE_W = bfh_pkg::LANE_W;
  localparam int PADN   = NGROUPS * LANES;

  logic [SYMBOLS-1:0] present_r;
  logic [SYMBOLS-1:0] present_nxt;
  logic [PADN-1:0]    pad;
  logic [GRP_W:0]     grp;
  logic               in_range;
  logic [GRP_W-1:0]   grp_i;
  logic [LANES-1:0]   lane_bits;
  logic [LANE_W-1:0]  lo;
  logic [LANE_W-1:0]  lane_sel;
  logic               hit;
  logic [PAD_W-1:0]   pidx;

  always_comb begin
    present_nxt = present_r;
    if (cmd.clr_all) begin
      present_nxt = '0;
    end else if (cmd.set_en) begin
      present_nxt[set_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else begin
      present_r <= present_nxt;
    end
  end

  assign rd_present = present_r[rd_idx];

  assign pad       = PADN'(present_r);
  assign grp       = cur[CUR_W-1:LANE_W];
  assign lo        = cur[LANE_W-1:0];
  assign in_range  = grp < (GRP_W + 1)'(NGROUPS);
  assign grp_i     = in_range ? grp[GRP_W-1:0] : '0;
  assign lane_bits = in_range ? pad[grp_i * LANES +: LANES] : '0;

  // lowest present lane at or above the cursor wins
  always_comb begin
    hit      = 1'b0;
    lane_sel = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (lane_bits[l] && (LANE_W'(l) >= lo)) begin
        hit      = 1'b1;
        lane_sel = LANE_W'(l);
      end
    end
  end

  assign pidx          = {grp_i, lane_sel};
  assign hit_idx       = pidx[IDX_W-1:0];
  assign stat.hit      = hit;
  assign stat.last_grp = grp >= (GRP_W + 1)'(NGROUPS - 1);

endmodule

/* hdl/bfh_checker.sv */
// Port-level checker for the byte frequency histogram, bound to the top level.
module bfh_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bfh_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]                      out_tuser,
  input logic                            out_tlast
);

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // hold a stalled word
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result word changed");

  // a word without an entry carries no symbol, count or last flag
  a_no_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[39:0] == 40'd0) && !out_tlast)
    else $error("non-entry word carries entry fields");

  // distinct count stays within the byte range and padding stays zero
  a_distinct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[48:40] <= 9'd256) && (out_tdata[55:49] == 7'd0))
    else $error("distinct count out of range or padding set");

endmodule

bind byte_frequency_histogram bfh_checker u_bfh_checker (.*);
